[rtl/ptd_pkg.sv]
// Shared types and constants for the prefix trie dictionary.
`default_nettype none

package ptd_pkg;

    localparam int MAX_NODES_DEF = 4096;
    localparam int ALPHABET_DEF  = 26;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_PREFIX = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] letter;
        logic       last;
        logic       empty_word;
    } t_req;

    typedef struct packed {
        logic found;
        logic table_full;
    } t_rsp;

    typedef struct packed {
        logic child;
        logic word_end;
    } t_store_we;

endpackage

`default_nettype wire

[rtl/prefix_trie_dictionary.sv]
// Prefix trie dictionary: top level with walk sequencer and result register.
// Words arrive one letter per request and walk a child table held in block
// memory from the root; inserts take new nodes from a bump pointer. After
// reset a clearing pass writes every child-table entry and word-end bit to
// zero with the input stalled. Each letter that reaches the child table then
// passes through S_LOOK, where the child table read result feeds the next
// letter's address; a letter that walks nothing (out of range, walk already
// failed) skips S_LOOK. The request that ends a word then passes through S_FIN
// to form the result, and an ending request that walks no letter (empty word,
// letter out of range, walk already failed) goes from S_IDLE straight to S_FIN.
// A result waits in an output register while the next word is accepted.
`default_nettype none

module prefix_trie_dictionary #(
    parameter int MAX_NODES = ptd_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = ptd_pkg::ALPHABET_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ptd_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ptd_pkg::t_rsp      o_rsp
);
    import ptd_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int DEPTH  = MAX_NODES * ALPHABET;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_last_alloc, n_last_alloc;
    logic              r_pm, n_pm;
    logic              r_pe, n_pe;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_op, n_op;
    logic              r_end, n_end;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_rsp              r_rsp, n_rsp;

    t_store_we         we;
    logic [ADDR_W-1:0] child_waddr;
    logic [NODE_W-1:0] child_wdata;
    logic [NODE_W-1:0] child_rdata;
    logic [NODE_W-1:0] end_waddr;
    logic              end_wdata;
    logic              end_rdata;
    logic [ADDR_W-1:0] slot;
    logic              letter_ok;
    logic [NODE_W-1:0] new_node;

    assign slot      = ADDR_W'(r_cur * ALPHABET) + ADDR_W'(i_req.letter);
    assign letter_ok = 32'(i_req.letter) < ALPHABET;
    assign new_node  = r_last_alloc + NODE_W'(1);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_last_alloc = r_last_alloc;
        n_pm         = r_pm;
        n_pe         = r_pe;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_end        = r_end;
        n_addr       = r_addr;
        n_rsp        = r_rsp;
        we           = '0;
        child_waddr  = r_addr;
        child_wdata  = new_node;
        end_waddr    = r_cur;
        end_wdata    = 1'b1;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                we.child    = 1'b1;
                child_waddr = r_clr;
                child_wdata = '0;
                we.word_end = (r_clr < ADDR_W'(MAX_NODES));
                end_waddr   = r_clr[NODE_W-1:0];
                end_wdata   = 1'b0;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = i_req.func;
                    n_end  = i_req.last || i_req.empty_word;
                    n_addr = slot;
                    if (!i_req.empty_word && !r_pm) begin
                        if (letter_ok) begin
                            n_state = S_LOOK;
                        end else begin
                            n_pm = 1'b1;
                            if (i_req.last) begin
                                n_state = S_FIN;
                            end
                        end
                    end else if (i_req.last || i_req.empty_word) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOOK: begin
                if (child_rdata != '0) begin
                    n_cur = child_rdata;
                end else if (r_op != OP_INSERT) begin
                    n_pm = 1'b1;
                end else if (r_last_alloc == NODE_W'(MAX_NODES - 1)) begin
                    n_pe = 1'b1;
                    n_pm = 1'b1;
                end else begin
                    we.child     = 1'b1;
                    n_last_alloc = new_node;
                    n_cur        = new_node;
                end
                n_state = r_end ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_rsp = '0;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_pe) begin
                                n_rsp.table_full = 1'b1;
                            end else if (!r_pm) begin
                                n_rsp.found = 1'b1;
                                we.word_end = 1'b1;
                            end
                        end
                        OP_SEARCH: n_rsp.found = !r_pm && end_rdata;
                        default:   n_rsp.found = !r_pm;
                    endcase
                    n_out_valid = 1'b1;
                    n_cur       = '0;
                    n_pm        = 1'b0;
                    n_pe        = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_cur        <= '0;
            r_last_alloc <= '0;
            r_pm         <= 1'b0;
            r_pe         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_cur        <= n_cur;
            r_last_alloc <= n_last_alloc;
            r_pm         <= n_pm;
            r_pe         <= n_pe;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_end  <= n_end;
        r_addr <= n_addr;
        r_rsp  <= n_rsp;
    end

    // word-end read follows the next node so it is ready in the final state
    ptd_store #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_store (
        .i_clk         (i_clk),
        .i_we          (we),
        .i_child_waddr (child_waddr),
        .i_child_wdata (child_wdata),
        .i_child_raddr (slot),
        .o_child_rdata (child_rdata),
        .i_end_waddr   (end_waddr),
        .i_end_wdata   (end_wdata),
        .i_end_raddr   (n_cur),
        .o_end_rdata   (end_rdata)
    );

endmodule

`default_nettype wire

[rtl/ptd_store.sv]
// Child table and word-end memories of the trie, with registered reads.
`default_nettype none

module ptd_store #(
    parameter int MAX_NODES = ptd_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = ptd_pkg::ALPHABET_DEF
) (
    input  wire logic                                   i_clk,
    input  wire ptd_pkg::t_store_we                     i_we,
    input  wire logic [$clog2(MAX_NODES*ALPHABET)-1:0]  i_child_waddr,
    input  wire logic [$clog2(MAX_NODES)-1:0]           i_child_wdata,
    input  wire logic [$clog2(MAX_NODES*ALPHABET)-1:0]  i_child_raddr,
    output logic      [$clog2(MAX_NODES)-1:0]           o_child_rdata,
    input  wire logic [$clog2(MAX_NODES)-1:0]           i_end_waddr,
    input  wire logic                                   i_end_wdata,
    input  wire logic [$clog2(MAX_NODES)-1:0]           i_end_raddr,
    output logic                                        o_end_rdata
);
    import ptd_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int DEPTH  = MAX_NODES * ALPHABET;

    logic [NODE_W-1:0] child_mem [DEPTH];
    logic              end_mem   [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_we.child) begin
            child_mem[i_child_waddr] <= i_child_wdata;
        end
        o_child_rdata <= child_mem[i_child_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.word_end) begin
            end_mem[i_end_waddr] <= i_end_wdata;
        end
        o_end_rdata <= end_mem[i_end_raddr];
    end

endmodule

`default_nettype wire

[tb/sv/prefix_trie_dictionary_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the prefix trie dictionary, driven by directed and random words.
module prefix_trie_dictionary_tb;
    import ptd_pkg::*;

    localparam int NODES          = MAX_NODES_DEF;
    localparam int ALPHA          = ALPHABET_DEF;
    localparam int WATCHDOG_LIMIT = 4 * NODES * ALPHA;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef enum {END_LAST, END_EMPTY, END_BOTH} t_end_mode;

    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][4:0] ch;
    } t_word;

    class trie_shadow;
        bit [11:0]   child_of [NODES*ALPHA];
        bit          word_mark [NODES];
        int unsigned top_node;
        int unsigned cur_node;
        bit          off_path;
        bit          out_of_nodes;
        t_rsp        pending_results[$];
        int          errors;

        function void apply_request(t_req r);
            int unsigned slot;
            t_rsp        rsp;
            if (!r.empty_word && !off_path) begin
                if (r.letter >= ALPHA) begin
                    off_path = 1'b1;
                end else begin
                    slot = cur_node * ALPHA + r.letter;
                    if (child_of[slot] == 0) begin
                        if (r.func != OP_INSERT) begin
                            off_path = 1'b1;
                        end else if (top_node + 1 >= NODES) begin
                            out_of_nodes = 1'b1;
                            off_path     = 1'b1;
                        end else begin
                            top_node++;
                            child_of[slot] = 12'(top_node);
                        end
                    end
                    if (!off_path)
                        cur_node = child_of[slot];
                end
            end
            if (!r.empty_word && !r.last)
                return;
            rsp = '0;
            case (r.func)
                OP_INSERT: begin
                    if (out_of_nodes) begin
                        rsp.table_full = 1'b1;
                    end else if (!off_path) begin
                        word_mark[cur_node] = 1'b1;
                        rsp.found = 1'b1;
                    end
                end
                OP_SEARCH: begin
                    if (!off_path)
                        rsp.found = word_mark[cur_node];
                end
                default: begin
                    rsp.found = !off_path;
                end
            endcase
            pending_results.push_back(rsp);
            cur_node     = 0;
            off_path     = 1'b0;
            out_of_nodes = 1'b0;
        endfunction

        function void compare_result(t_rsp got);
            t_rsp want;
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: found=%0b table_full=%0b",
                       got.found, got.table_full);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0b, actual %0b", want.found, got.found);
                errors++;
            end
            if (got.table_full !== want.table_full) begin
                $error("table_full: expected %0b, actual %0b", want.table_full, got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    trie_shadow sb;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         requests_sent = 0;
    t_word      stored_words[$];

    prefix_trie_dictionary dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.compare_result(o_rsp);
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] func, input logic [4:0] letter,
                             input bit last, input bit empty);
        t_req req;
        req.func       = func;
        req.letter     = letter;
        req.last       = last;
        req.empty_word = empty;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        sb.apply_request(req);
        requests_sent++;
    endtask

    // letters go out under op; when mix is set, each letter may take a random op instead
    task automatic send_word(input t_word w, input logic [1:0] op, input t_end_mode mode,
                             input bit mix);
        logic [1:0] f;
        for (int k = 0; k < w.len; k++) begin
            f = (mix && $urandom_range(1)) ? 2'($urandom_range(3)) : op;
            send_item(f, w.ch[k], mode == END_LAST && k == w.len - 1, 1'b0);
        end
        if (mode != END_LAST || w.len == 0)
            send_item(op, 5'($urandom_range(31)), mode == END_BOTH, 1'b1);
    endtask

    function automatic t_word rand_word(int min_len, int max_len, int top_letter);
        t_word w;
        w = '0;
        w.len = 4'($urandom_range(max_len, min_len));
        for (int k = 0; k < 8; k++)
            w.ch[k] = 5'($urandom_range(top_letter));
        return w;
    endfunction

    task automatic run_random(input int n);
        int        stop_at;
        int        pick;
        t_word     w;
        t_end_mode mode;
        stop_at = requests_sent + n;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(19);
            if (pick < 14)
                mode = END_LAST;
            else if (pick < 17)
                mode = END_EMPTY;
            else
                mode = END_BOTH;
            pick = $urandom_range(99);
            if (pick < 35) begin
                w = rand_word(1, 5, (pick < 5) ? 25 : 3);
                send_word(w, OP_INSERT, mode, 1'b0);
                stored_words.push_back(w);
                if (stored_words.size() > 300)
                    stored_words.delete(0);
            end else if (pick < 75 && stored_words.size() != 0) begin
                w = stored_words[$urandom_range(stored_words.size() - 1)];
                if ($urandom_range(3) == 0)
                    w.len = 4'($urandom_range(w.len));
                if (pick < 60)
                    send_word(w, OP_SEARCH, mode, 1'b0);
                else
                    send_word(w, $urandom_range(1) ? OP_PREFIX : OP_SPARE, mode, 1'b0);
            end else if (pick < 90) begin
                w = rand_word(0, 5, 3);
                send_word(w, $urandom_range(1) ? OP_SEARCH : OP_PREFIX, mode, 1'b0);
            end else begin
                w = rand_word(0, 6, 31);
                send_word(w, 2'($urandom_range(3)), mode, 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        send_idle = 33;
        recv_idle <= 62;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty string: insert, search, prefix
        send_item(OP_INSERT, 5'd0, 1'b0, 1'b1);
        send_item(OP_SEARCH, 5'd7, 1'b0, 1'b1);
        send_item(OP_PREFIX, 5'd31, 1'b1, 1'b1);
        // single letters at both ends of the alphabet
        send_item(OP_INSERT, 5'd0, 1'b1, 1'b0);
        send_item(OP_INSERT, 5'd25, 1'b1, 1'b0);
        send_item(OP_SEARCH, 5'd25, 1'b1, 1'b0);
        send_item(OP_SEARCH, 5'd1, 1'b1, 1'b0);
        send_item(OP_SPARE, 5'd0, 1'b1, 1'b0);
        // letter out of range on insert
        send_item(OP_INSERT, 5'd31, 1'b1, 1'b0);
        // last and empty together: letter not taken
        send_item(OP_INSERT, 5'd25, 1'b0, 1'b0);
        send_item(OP_INSERT, 5'd0, 1'b1, 1'b1);
        send_item(OP_SEARCH, 5'd25, 1'b0, 1'b0);
        send_item(OP_SEARCH, 5'd0, 1'b0, 1'b1);
        // op changes within a word
        send_item(OP_INSERT, 5'd24, 1'b0, 1'b0);
        send_item(OP_SEARCH, 5'd23, 1'b1, 1'b0);
        send_item(OP_SEARCH, 5'd24, 1'b0, 1'b0);
        send_item(OP_INSERT, 5'd23, 1'b1, 1'b0);
        // walk already failed, then more letters
        send_item(OP_SEARCH, 5'd16, 1'b0, 1'b0);
        send_item(OP_SEARCH, 5'd0, 1'b1, 1'b0);
        send_item(OP_PREFIX, 5'd25, 1'b0, 1'b0);
        send_item(OP_PREFIX, 5'd30, 1'b0, 1'b0);
        send_item(OP_PREFIX, 5'd0, 1'b1, 1'b0);

        run_random(600);
        send_idle = 62;
        recv_idle <= 33;
        run_random(600);
        send_idle = 0;
        recv_idle <= 0;
        run_random(550);

        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/ptd_pkg.sv
rtl/ptd_store.sv
rtl/prefix_trie_dictionary.sv
tb/sv/prefix_trie_dictionary_tb.sv
